@@ design/rfbw_pkg.sv @@
`default_nettype none
package rfbw_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	localparam int COUNT_W = 6;
	localparam int VALUE_W = 32;
	localparam int WM_W    = 7;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [WM_W-1:0] WM_RESET = 7'd64;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_QUOTA     = 2'd1,
		ST_NOROOM    = 2'd2,
		ST_NOTENOUGH = 2'd3
	} status_t;

	typedef enum logic {
		REG_WM = 1'b0
	} reg_idx_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DEQ  = 1'b1
	} fsm_t;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   value;
		logic                 last;
		logic                 full;
		logic                 empty;
	} result_t;

endpackage
`default_nettype wire

@@ design/rfbw_if.sv @@
`default_nettype none
interface rfbw_in_if;
	import rfbw_pkg::*;
	logic               valid;
	logic               ready;
	cmd_t               cmd;
	logic [COUNT_W-1:0] count;
	logic [VALUE_W-1:0] value;
	modport source(output valid, cmd, count, value, input ready);
	modport sink(input valid, cmd, count, value, output ready);
endinterface

interface rfbw_out_if;
	import rfbw_pkg::*;
	logic               valid;
	logic               ready;
	status_t            status;
	logic [VALUE_W-1:0] out_value;
	logic               last;
	logic               full_res;
	logic               empty_res;
	modport source(output valid, status, out_value, last, full_res, empty_res, input ready);
	modport sink(input valid, status, out_value, last, full_res, empty_res, output ready);
endinterface
`default_nettype wire

@@ design/ring_fifo_burst_watermark.sv @@
// channel   dir  handshake      words
// in_ch     in   valid/ready    cmd, count, value
// out_ch    out  valid/ready    status, out_value, last, full_res, empty_res
// apb       in   psel/penable   watermark at byte address 0
//
// Enqueue items: one a cycle while ready; word stored on accept if the burst fits.
// Dequeue of n words: one store read a cycle while the result queue has room;
// each word goes via rd_data_s1 to the queue; the next item is taken after the last.
// Reset clears indices, burst state, result queue and watermark (64), not the store.
// A two-entry result queue absorbs out_ch stalls; input is held off while it is
// full, during a dequeue burst and while its last word waits in rd_data_s1.
`default_nettype none
module ring_fifo_burst_watermark #(
	parameter int DEPTH     = rfbw_pkg::DEPTH_DEF,
	parameter int WORD_BITS = rfbw_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rfbw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rfbw_pkg::DATA_W-1:0] pwdata,
	output logic      [rfbw_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	rfbw_in_if.sink                          in_ch,
	rfbw_out_if.source                       out_ch
);
	import rfbw_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW > WM_W ? AW : WM_W) + 2;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_s1;
	logic                 pend_s1;
	logic                 last_s1;

	logic [WM_W-1:0]    wm_q;
	logic [AW-1:0]      wi_q, ri_q;
	logic [COUNT_W-1:0] burst_left_q;
	logic               burst_acc_q, burst_quota_q;
	fsm_t               state_q, state_d;
	logic [COUNT_W-1:0] deq_left_q;
	logic               deq_full_q, deq_empty_q;

	result_t    oq_q [2];
	logic       oq_head_q, oq_tail_q;
	logic [1:0] oq_cnt_q;

	logic [AW-1:0]      occ;
	logic [AW:0]        occ_w;
	logic [CW-1:0]      free_c;
	logic [COUNT_W-1:0] cnt_eff, left_new;
	logic               enq_start, acc_cur, quota_cur, enq_done;
	logic [AW-1:0]      occ_enq;
	logic               in_acc, is_enq, is_deq, pop, issue, room;
	logic               deq_ok, deq_go;
	logic [AW-1:0]      occ_deq;
	logic [2:0]         oq_need;
	logic               push;
	result_t            push_data, acc_res;

	// apb
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WM)
			prdata = DATA_W'(wm_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q <= WM_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WM) begin
			wm_q <= pwdata[WM_W-1:0];
		end
	end

	// occupancy
	always_comb begin
		if (wi_q >= ri_q)
			occ_w = (AW+1)'(wi_q) - (AW+1)'(ri_q);
		else
			occ_w = (AW+1)'(wi_q) + (AW+1)'(DEPTH) - (AW+1)'(ri_q);
		occ    = occ_w[AW-1:0];
		free_c = CW'(DEPTH - 1) - CW'(occ);
	end

	// enqueue decision
	always_comb begin
		enq_start = (burst_left_q == '0);
		cnt_eff   = (in_ch.count == '0) ? COUNT_W'(1) : in_ch.count;
		if (enq_start) begin
			acc_cur   = CW'(cnt_eff) <= free_c;
			quota_cur = (CW'(occ) + CW'(cnt_eff) + CW'(1)) > CW'(wm_q);
			left_new  = cnt_eff - COUNT_W'(1);
		end else begin
			acc_cur   = burst_acc_q;
			quota_cur = burst_quota_q;
			left_new  = burst_left_q - COUNT_W'(1);
		end
		enq_done = (left_new == '0);
		occ_enq  = occ + AW'(acc_cur);
	end

	// dequeue decision
	always_comb begin
		deq_ok  = (in_ch.count != '0) && (CW'(in_ch.count) <= CW'(occ));
		occ_deq = occ - AW'(in_ch.count);
	end

	// result queue
	assign pop          = out_ch.valid && out_ch.ready;
	assign out_ch.valid = (oq_cnt_q != 2'd0);
	always_comb begin
		out_ch.status    = oq_q[oq_head_q].status;
		out_ch.out_value = oq_q[oq_head_q].value;
		out_ch.last      = oq_q[oq_head_q].last;
		out_ch.full_res  = oq_q[oq_head_q].full;
		out_ch.empty_res = oq_q[oq_head_q].empty;
	end
	assign oq_need = 3'(oq_cnt_q) + 3'(pend_s1) - 3'(pop);
	assign room    = (oq_need < 3'd2);

	// fsm: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (deq_go) state_d = S_DEQ;
			S_DEQ:   if (issue && deq_left_q == COUNT_W'(1)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		in_ch.ready = 1'b0;
		issue       = 1'b0;
		case (state_q)
			S_IDLE:  in_ch.ready = !pend_s1 && room;
			S_DEQ:   issue = room;
			default: ;
		endcase
	end

	assign in_acc = in_ch.valid && in_ch.ready;
	assign is_enq = in_acc && in_ch.cmd == CMD_ENQ;
	assign is_deq = in_acc && in_ch.cmd == CMD_DEQ;
	assign deq_go = is_deq && deq_ok;

	always_comb begin
		acc_res = '{status: ST_OK, value: '0, last: 1'b1,
			full: (occ == LAST_IDX), empty: (occ == '0)};
		if (in_ch.cmd == CMD_ENQ) begin
			acc_res.status = !acc_cur ? ST_NOROOM : (quota_cur ? ST_QUOTA : ST_OK);
			acc_res.full   = (occ_enq == LAST_IDX);
			acc_res.empty  = (occ_enq == '0);
		end else if (in_ch.count != '0) begin
			acc_res.status = ST_NOTENOUGH;
		end
		if (pend_s1) begin
			push_data = '{status: ST_OK, value: VALUE_W'(rd_data_s1), last: last_s1,
				full: deq_full_q, empty: deq_empty_q};
		end else begin
			push_data = acc_res;
		end
		push = pend_s1 || (is_enq && enq_done) || (is_deq && !deq_ok);
	end

	always_ff @(posedge clk) begin
		if (push)
			oq_q[oq_tail_q] <= push_data;
	end

	// store
	always_ff @(posedge clk) begin
		if (is_enq && acc_cur)
			mem[wi_q] <= WORD_BITS'(in_ch.value);
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_data_s1 <= mem[ri_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wi_q          <= '0;
			ri_q          <= '0;
			burst_left_q  <= '0;
			burst_acc_q   <= 1'b0;
			burst_quota_q <= 1'b0;
			deq_left_q    <= '0;
			deq_full_q    <= 1'b0;
			deq_empty_q   <= 1'b0;
			pend_s1       <= 1'b0;
			last_s1       <= 1'b0;
			oq_head_q     <= 1'b0;
			oq_tail_q     <= 1'b0;
			oq_cnt_q      <= 2'd0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (issue) begin
				last_s1    <= (deq_left_q == COUNT_W'(1));
				deq_left_q <= deq_left_q - COUNT_W'(1);
				ri_q       <= (ri_q == LAST_IDX) ? '0 : ri_q + AW'(1);
			end
			if (is_enq) begin
				burst_left_q  <= left_new;
				burst_acc_q   <= enq_done ? 1'b0 : acc_cur;
				burst_quota_q <= enq_done ? 1'b0 : quota_cur;
				if (acc_cur)
					wi_q <= (wi_q == LAST_IDX) ? '0 : wi_q + AW'(1);
			end
			if (deq_go) begin
				deq_left_q  <= in_ch.count;
				deq_full_q  <= (occ_deq == LAST_IDX);
				deq_empty_q <= (occ_deq == '0);
			end
			if (push)
				oq_tail_q <= ~oq_tail_q;
			if (pop)
				oq_head_q <= ~oq_head_q;
			oq_cnt_q <= oq_cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

@@ design/rfbw_chk.sv @@
`default_nettype none
module rfbw_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire rfbw_pkg::status_t            status,
	input wire logic [rfbw_pkg::VALUE_W-1:0] out_value,
	input wire logic                         last,
	input wire logic                         full_res,
	input wire logic                         empty_res
);
	import rfbw_pkg::*;

	a_no_valid_in_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value)
			&& $stable(last))
		else $error("stalled result changed");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_value == '0 && last)
		else $error("status result carries a word or is not last");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(full_res && empty_res))
		else $error("full and empty together");

endmodule

bind ring_fifo_burst_watermark rfbw_chk u_rfbw_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.status    (out_ch.status),
	.out_value (out_ch.out_value),
	.last      (out_ch.last),
	.full_res  (out_ch.full_res),
	.empty_res (out_ch.empty_res)
);
`default_nettype wire

@@ verif/tb_ring_fifo_burst_watermark.sv @@
`timescale 1ns / 1ps
module tb_ring_fifo_burst_watermark;
	import rfbw_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int USABLE = DEPTH - 1;
	localparam int DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [ADDR_W-1:0] WM_ADDR = ADDR_W'(4 * int'(REG_WM));

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic rx_ready = 1'b0;

	rfbw_in_if in_bus();
	rfbw_out_if out_bus();

	assign out_bus.ready = rx_ready;

	ring_fifo_burst_watermark #(
		.DEPTH(DEPTH),
		.WORD_BITS(WORD_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_bus),
		.out_ch(out_bus)
	);

	always #5 clk = ~clk;

	// mirror of the ring and burst state
	logic [VALUE_W-1:0] mirror_store [DEPTH];
	int unsigned wr_ptr, rd_ptr;
	int unsigned words_left;
	bit burst_fits, burst_over;
	logic [WM_W-1:0] mirror_wm;
	result_t results_due[$];

	int mismatches;
	int items_sent;
	int src_idle_pct, snk_idle_pct;
	int hold_req, hold_left;
	int unsigned cycle_count;
	result_t want;

	function automatic int unsigned stored_words();
		return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
	endfunction

	function automatic void queue_result(status_t s, logic [VALUE_W-1:0] v, logic l);
		result_t r;
		r.status = s;
		r.value = v;
		r.last = l;
		r.full = stored_words() == USABLE;
		r.empty = stored_words() == 0;
		results_due.push_back(r);
	endfunction

	function automatic void mirror_item(cmd_t c, logic [COUNT_W-1:0] n, logic [VALUE_W-1:0] v);
		int unsigned cnt;
		int unsigned occ;
		logic [VALUE_W-1:0] taken[$];
		cnt = n;
		if (c == CMD_ENQ) begin
			if (words_left == 0) begin
				occ = stored_words();
				if (cnt == 0) cnt = 1;
				words_left = cnt;
				burst_fits = cnt <= USABLE - occ;
				burst_over = occ + cnt + 1 > mirror_wm;
			end
			if (burst_fits) begin
				mirror_store[wr_ptr] = v;
				wr_ptr = (wr_ptr + 1) % DEPTH;
			end
			words_left--;
			if (words_left == 0) begin
				queue_result(burst_fits ? (burst_over ? ST_QUOTA : ST_OK) : ST_NOROOM, '0, 1'b1);
				burst_fits = 0;
				burst_over = 0;
			end
		end else if (cnt == 0) begin
			queue_result(ST_OK, '0, 1'b1);
		end else if (cnt > stored_words()) begin
			queue_result(ST_NOTENOUGH, '0, 1'b1);
		end else begin
			for (int k = 0; k < cnt; k++) begin
				taken.push_back(mirror_store[rd_ptr]);
				rd_ptr = (rd_ptr + 1) % DEPTH;
			end
			for (int k = 0; k < cnt; k++)
				queue_result(ST_OK, taken[k], k == cnt - 1);
		end
	endfunction

	function automatic void check_field(string what, logic [VALUE_W-1:0] exp_v,
			logic [VALUE_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
		end
	endfunction

	// receiver: checks each result word, drives ready
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (out_bus.valid && rx_ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual status %0d value %h",
						$time, out_bus.status, out_bus.out_value);
				end else begin
					want = results_due.pop_front();
					check_field("status", VALUE_W'(want.status), VALUE_W'(out_bus.status));
					check_field("out_value", want.value, out_bus.out_value);
					check_field("last", VALUE_W'(want.last), VALUE_W'(out_bus.last));
					check_field("full_res", VALUE_W'(want.full), VALUE_W'(out_bus.full_res));
					check_field("empty_res", VALUE_W'(want.empty), VALUE_W'(out_bus.empty_res));
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= $urandom_range(99) >= snk_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_item(cmd_t c, logic [COUNT_W-1:0] n, logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.cmd <= c;
		in_bus.count <= n;
		in_bus.value <= v;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		mirror_item(c, n, v);
		items_sent++;
	endtask

	task automatic wait_drain();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(bit wr, logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= WM_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_watermark(logic [WM_W-1:0] wm);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, DATA_W'(wm), rd);
		mirror_wm = wm;
		apb_access(1'b0, '0, rd);
		check_field("watermark readback", VALUE_W'(wm), VALUE_W'(rd[WM_W-1:0]));
	endtask

	// messy bursts carry junk count fields and dequeues between their words
	task automatic send_enq_burst(int len, bit messy);
		int items;
		items = (len == 0) ? 1 : len;
		for (int k = 0; k < items; k++) begin
			if (messy && k > 0 && $urandom_range(5) == 0)
				push_item(CMD_DEQ, COUNT_W'($urandom_range(4)), $urandom);
			push_item(CMD_ENQ, (messy && k > 0) ? COUNT_W'($urandom) : COUNT_W'(len), $urandom);
		end
	endtask

	task automatic run_directed();
		logic [DATA_W-1:0] rd;
		apb_access(1'b0, '0, rd);
		check_field("watermark reset", VALUE_W'(WM_RESET), VALUE_W'(rd[WM_W-1:0]));
		push_item(CMD_DEQ, 6'd1, 32'hDEAD_BEEF);
		push_item(CMD_DEQ, 6'd0, 32'h0);
		push_item(CMD_ENQ, 6'd0, 32'hFFFF_FFFF);
		push_item(CMD_ENQ, 6'd3, 32'h0000_0000);
		push_item(CMD_ENQ, 6'h3F, 32'hA5A5_5A5A);
		push_item(CMD_ENQ, 6'h00, 32'h5A5A_A5A5);
		push_item(CMD_ENQ, 6'd2, 32'h1234_5678);
		push_item(CMD_DEQ, 6'd2, 32'hFFFF_FFFF);
		push_item(CMD_ENQ, 6'd2, 32'h8765_4321);
		push_item(CMD_DEQ, 6'd5, 32'h0);
		push_item(CMD_DEQ, 6'd4, 32'h0);
		wait_drain();
		set_watermark(7'd3);
		push_item(CMD_ENQ, 6'd2, 32'h0000_0001);
		push_item(CMD_ENQ, 6'd2, 32'h8000_0000);
		push_item(CMD_ENQ, 6'd1, 32'h7FFF_FFFF);
		push_item(CMD_DEQ, 6'd3, 32'h0);
		wait_drain();
	endtask

	task automatic run_full_and_stall();
		set_watermark(7'd63);
		if (stored_words() != 0)
			push_item(CMD_DEQ, COUNT_W'(stored_words()), '0);
		hold_req = 400;
		send_enq_burst(USABLE, 0);
		push_item(CMD_ENQ, 6'd1, $urandom);
		push_item(CMD_DEQ, 6'd63, $urandom);
		push_item(CMD_DEQ, 6'd1, $urandom);
		wait_drain();
		send_enq_burst(5, 0);
		push_item(CMD_DEQ, 6'd5, $urandom);
		wait_drain();
	endtask

	task automatic run_random_traffic(int n_items, logic [WM_W-1:0] wm);
		int stop_at;
		int occ;
		int pick;
		int len;
		set_watermark(wm);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			occ = stored_words();
			pick = $urandom_range(99);
			if (pick < 55 && occ < USABLE) begin
				case ($urandom_range(9))
					0: len = $urandom_range(63);
					1: len = USABLE - occ;
					default: len = $urandom_range(1, (USABLE - occ < 8) ? USABLE - occ : 8);
				endcase
				send_enq_burst(len, $urandom_range(4) == 0);
			end else if (pick < 92 && occ > 0) begin
				if ($urandom_range(7) == 0)
					len = occ;
				else
					len = $urandom_range(1, (occ < 12) ? occ : 12);
				push_item(CMD_DEQ, COUNT_W'(len), $urandom);
			end else begin
				push_item(CMD_DEQ, COUNT_W'($urandom), $urandom);
			end
		end
		wait_drain();
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.cmd = CMD_ENQ;
		in_bus.count = '0;
		in_bus.value = '0;
		mirror_wm = WM_RESET;
		src_idle_pct = 30;
		snk_idle_pct = 78;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random_traffic(80, 7'd127);
		run_full_and_stall();
		src_idle_pct = 78;
		snk_idle_pct = 30;
		run_random_traffic(80, 7'd0);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_random_traffic(80, WM_W'($urandom_range(1, 126)));
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
